// File: hw/rtl/dsdv_pkg.sv
//------------------------------------------------------------------------------
// dsdv_pkg
// Shared types and constants of the decaying sine drum voice: sequencer
// states, register map, fixed-point constants and unit handshakes.
//------------------------------------------------------------------------------
`default_nettype none

package dsdv_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 36;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // tanh divider widths
   localparam int DIV_NUM_W = 54;
   localparam int DIV_DEN_W = 38;
   localparam int DIV_Q_W   = 15;

   // register map (word index)
   localparam logic [2:0] REG_ENABLED     = 3'd0;
   localparam logic [2:0] REG_DECAY_COEFF = 3'd1;
   localparam logic [2:0] REG_DRIVE_GAIN  = 3'd2;
   localparam logic [2:0] REG_TONE_ALPHA  = 3'd3;
   localparam logic [2:0] REG_OUTPUT_GAIN = 3'd4;

   // register reset values
   localparam logic [23:0] DECAY_RESET = 24'd16774742;
   localparam logic [15:0] DRIVE_RESET = 16'd7168;
   localparam logic [15:0] ALPHA_RESET = 16'd10742;
   localparam logic [14:0] OGAIN_RESET = 15'd8192;

   // item kinds and MIDI codes
   localparam logic       OP_TICK        = 1'b0;
   localparam logic       OP_MIDI        = 1'b1;
   localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
   localparam logic [1:0] EVENT_FULL_LEN = 2'd3;

   // fixed-point constants
   localparam logic [23:0] ENV_FULL    = 24'hFFFFFF;
   localparam logic [23:0] ENV_FLOOR   = 24'd168;
   localparam logic [15:0] VEL_MIN     = 16'd1638;
   localparam logic [23:0] K065_Q15    = 24'd21299;
   localparam logic [23:0] K09_Q15     = 24'd29491;
   localparam logic [19:0] TANH_LIMIT  = 20'd163840;
   localparam logic [37:0] TANH_C0     = 38'd4428103680;
   localparam logic [23:0] TANH_N2     = 24'd17325;
   localparam logic [23:0] TANH_N4     = 24'd378;
   localparam logic [23:0] TANH_D2     = 24'd62370;
   localparam logic [23:0] TANH_D4     = 24'd3150;
   localparam logic [23:0] TANH_D6     = 24'd28;
   localparam logic [14:0] Q15_MAX     = 15'h7FFF;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ENV,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_TH_START,
      ST_TH_X2,
      ST_TH_X4,
      ST_TH_X6,
      ST_TH_D1,
      ST_TH_D2,
      ST_TH_D3,
      ST_TH_N1,
      ST_TH_N2,
      ST_TH_N3,
      ST_TH_DIV,
      ST_LP_ISSUE,
      ST_LP_UPD,
      ST_G1,
      ST_G2
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/decaying_sine_drum_voice_core.sv
//------------------------------------------------------------------------------
// decaying_sine_drum_voice_core
// Monophonic kick-style voice: note-on events restart a decaying sine,
// sample ticks return one Q1.15 sample.
//------------------------------------------------------------------------------
// A MIDI event is handled in the idle state; a tick while the voice is off or the
// block disabled returns silence in the cycle after it is accepted. A sounding
// tick runs through one shared multiplier under a sequencer: five products
// for envelope decay, sine, velocity, 0.65 and drive; a tanh of nine
// multiplies plus a wait on the divider; three multiplies for lowpass and
// output gain; and a second tanh. A tanh input of 5.0 or more skips that
// tanh's multiplies and divider, and a ratio that clamps at full scale ends
// the divider wait without the bit-serial division. A tick whose envelope
// falls below the floor returns silence and skips the rest of the sequence.
// The input side is not ready while a tick is in flight or its sample has
// not been taken.
`default_nettype none

module decaying_sine_drum_voice_core import dsdv_pkg::*; #(
   parameter int SAMPLE_RATE      = 44100,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // event_length[1:0], midi_status[9:2],
                                        // note_number[16:10], note_velocity[23:17]
   input  wire logic        req_tuser,  // operation[0]
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // audio_sample[15:0]
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH);
   localparam logic [63:0] STEP_DEN  = 64'(SAMPLE_RATE) << 10;
   localparam logic [63:0] STEP_HALF = STEP_DEN / 2;

   typedef logic [31:0] step_tab_type [128];
   typedef logic [15:0] vel_tab_type [128];

   // phase step per note, semitone power built in Q2.30
   function automatic logic [31:0] note_step(input int n);
      logic [63:0] r;
      logic [63:0] num;
      logic [63:0] q;
      int          d;
      int          oct;
      int          semi;
      d    = n + 51;
      oct  = d / 12;
      semi = d % 12;
      r    = 64'd1 << 30;
      for (int i = 0; i < semi; i++) begin
         r = (r * 64'd1137589835 + (64'd1 << 29)) >> 30;
      end
      num = (64'd1760 * r) << oct;
      q   = (num + STEP_HALF) / STEP_DEN;
      return q[31:0];
   endfunction

   function automatic step_tab_type build_step();
      step_tab_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = note_step(i);
      end
      return t;
   endfunction

   function automatic vel_tab_type build_vel();
      vel_tab_type t;
      logic [31:0] vs;
      for (int i = 0; i < 128; i++) begin
         vs = (32'(i) * 32'd32768 + 32'd63) / 32'd127;
         t[i] = (vs < 32'(VEL_MIN)) ? VEL_MIN : vs[15:0];
      end
      return t;
   endfunction

   localparam step_tab_type STEP_TAB = build_step();
   localparam vel_tab_type  VEL_TAB  = build_vel();

   // ---------------------------------------------------------------- state
   state_type          state_ff, state_in;
   logic               enabled_ff, enabled_in;
   logic [23:0]        decay_ff, decay_in;
   logic [15:0]        drive_ff, drive_in;
   logic [15:0]        alpha_ff, alpha_in;
   logic [14:0]        ogain_ff, ogain_in;
   logic               voice_on_ff, voice_on_in;
   logic [31:0]        phase_ff, phase_in;
   logic [31:0]        step_ff, step_in;
   logic [23:0]        env_ff, env_in;
   logic [15:0]        vel_ff, vel_in;
   logic signed [23:0] lp_ff, lp_in;
   logic               sign_ff, sign_in;
   logic [19:0]        m_ff, m_in;
   logic [19:0]        x2_ff, x2_in;
   logic [24:0]        x4_ff, x4_in;
   logic [28:0]        x6_ff, x6_in;
   logic [37:0]        acc_ff, acc_in;
   logic [37:0]        den_ff, den_in;
   logic               pass_ff, pass_in;
   logic [15:0]        th_ff, th_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- units
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic signed [15:0] rom_data;

   dsdv_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   dsdv_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   dsdv_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock   (clock),
      .rd_addr (phase_ff[31 -: ROM_AW]),
      .rd_data (rom_data)
   );

   // ---------------------------------------------------------------- decode
   logic        req_fire;
   logic        is_tick;
   logic        voice_live;
   logic        note_on;
   logic [1:0]  ev_len;
   logic [7:0]  ev_status;
   logic [6:0]  ev_note;
   logic [6:0]  ev_vel;
   logic        csr_wr;
   logic [2:0]  csr_idx;
   logic [23:0] env_new;
   logic        env_end;
   logic        th_sat;
   logic        th_done;
   logic [14:0] th_val;
   logic [15:0] th_signed;

   assign ev_len    = req_tdata[1:0];
   assign ev_status = req_tdata[9:2];
   assign ev_note   = req_tdata[16:10];
   assign ev_vel    = req_tdata[23:17];

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign is_tick    = (req_tuser == OP_TICK);
   assign voice_live = enabled_ff && voice_on_ff;
   assign note_on    = enabled_ff && (req_tuser == OP_MIDI) && (ev_len == EVENT_FULL_LEN)
                       && (ev_status[7:4] == STATUS_NOTE_ON) && (ev_vel != 7'd0);

   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[4:2];

   // envelope after this tick's decay
   assign env_new = prod[47:24];
   assign env_end = env_new < ENV_FLOOR;

   // tanh result: saturated input or divider quotient
   assign th_sat    = (state_ff == ST_TH_START) && (m_ff >= TANH_LIMIT);
   assign th_done   = th_sat || ((state_ff == ST_TH_DIV) && div_rsp.done);
   assign th_val    = th_sat ? Q15_MAX : div_rsp.quot;
   assign th_signed = sign_ff ? -{1'b0, th_val} : {1'b0, th_val};

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_tick && voice_live) begin
               state_in = ST_ENV;
            end
         end
         ST_ENV:      state_in = env_end ? ST_IDLE : ST_M1;
         ST_M1:       state_in = ST_M2;
         ST_M2:       state_in = ST_M3;
         ST_M3:       state_in = ST_M4;
         ST_M4:       state_in = ST_TH_START;
         ST_TH_START: begin
            if (th_sat) begin
               state_in = pass_ff ? ST_IDLE : ST_LP_ISSUE;
            end else begin
               state_in = ST_TH_X2;
            end
         end
         ST_TH_X2:    state_in = ST_TH_X4;
         ST_TH_X4:    state_in = ST_TH_X6;
         ST_TH_X6:    state_in = ST_TH_D1;
         ST_TH_D1:    state_in = ST_TH_D2;
         ST_TH_D2:    state_in = ST_TH_D3;
         ST_TH_D3:    state_in = ST_TH_N1;
         ST_TH_N1:    state_in = ST_TH_N2;
         ST_TH_N2:    state_in = ST_TH_N3;
         ST_TH_N3:    state_in = ST_TH_DIV;
         ST_TH_DIV: begin
            if (th_done) begin
               state_in = pass_ff ? ST_IDLE : ST_LP_ISSUE;
            end
         end
         ST_LP_ISSUE: state_in = ST_LP_UPD;
         ST_LP_UPD:   state_in = ST_G1;
         ST_G1:       state_in = ST_G2;
         ST_G2:       state_in = ST_TH_START;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      logic [15:0]        rom_mag;
      logic signed [25:0] d;
      logic signed [25:0] d_neg;
      logic [24:0]        d_mag;
      logic [24:0]        delta;
      logic signed [25:0] lp_new;
      logic signed [25:0] lp_neg;
      logic [23:0]        lp_mag;
      logic [37:0]        poly;

      rom_mag = rom_data[15] ? 16'(-rom_data) : rom_data;
      d       = {{2{th_ff[15]}}, th_ff, 8'd0} - {{2{lp_ff[23]}}, lp_ff};
      d_neg   = -d;
      d_mag   = d[25] ? d_neg[24:0] : d[24:0];
      delta   = prod[40:16];
      lp_new  = {{2{lp_ff[23]}}, lp_ff}
                + (sign_ff ? -$signed({1'b0, delta}) : $signed({1'b0, delta}));
      lp_neg  = -lp_new;
      lp_mag  = lp_new[25] ? lp_neg[23:0] : lp_new[23:0];
      poly    = acc_ff + prod[37:0] + {9'd0, x6_ff};

      enabled_in   = enabled_ff;
      decay_in     = decay_ff;
      drive_in     = drive_ff;
      alpha_in     = alpha_ff;
      ogain_in     = ogain_ff;
      voice_on_in  = voice_on_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      env_in       = env_ff;
      vel_in       = vel_ff;
      lp_in        = lp_ff;
      sign_in      = sign_ff;
      m_in         = m_ff;
      x2_in        = x2_ff;
      x4_in        = x4_ff;
      x6_in        = x6_ff;
      acc_in       = acc_ff;
      den_in       = den_ff;
      pass_in      = pass_ff;
      th_in        = th_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req.start = 1'b0;
      div_req.num   = prod[DIV_NUM_W-1:0];
      div_req.den   = den_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_tick) begin
                  if (voice_live) begin
                     phase_in = phase_ff + step_ff;
                     mul_a    = env_ff;
                     mul_b    = {12'd0, decay_ff};
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               end else if (note_on) begin
                  voice_on_in = 1'b1;
                  phase_in    = '0;
                  env_in      = ENV_FULL;
                  vel_in      = VEL_TAB[ev_vel];
                  step_in     = STEP_TAB[ev_note];
               end
            end
         end
         ST_ENV: begin
            if (env_end) begin
               env_in       = '0;
               voice_on_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
            end else begin
               env_in  = env_new;
               sign_in = rom_data[15];
               mul_a   = env_new;
               mul_b   = {20'd0, rom_mag};
            end
         end
         ST_M1: begin
            mul_a = {8'd0, vel_ff};
            mul_b = {20'd0, prod[39:24]};
         end
         ST_M2: begin
            mul_a = K065_Q15;
            mul_b = {20'd0, prod[30:15]};
         end
         ST_M3: begin
            mul_a = {8'd0, drive_ff};
            mul_b = {20'd0, prod[30:15]};
         end
         ST_M4: begin
            m_in    = prod[31:12];
            pass_in = 1'b0;
         end
         // tanh: powers of x, then denominator, then numerator times x
         ST_TH_START: begin
            mul_a = {4'd0, m_ff};
            mul_b = {16'd0, m_ff};
         end
         ST_TH_X2: begin
            x2_in = prod[34:15];
            mul_a = {4'd0, prod[34:15]};
            mul_b = {16'd0, prod[34:15]};
         end
         ST_TH_X4: begin
            x4_in = prod[39:15];
            mul_a = {4'd0, x2_ff};
            mul_b = {11'd0, prod[39:15]};
         end
         ST_TH_X6: begin
            x6_in = prod[43:15];
            mul_a = TANH_D2;
            mul_b = {16'd0, x2_ff};
         end
         ST_TH_D1: begin
            acc_in = TANH_C0 + prod[37:0];
            mul_a  = TANH_D4;
            mul_b  = {11'd0, x4_ff};
         end
         ST_TH_D2: begin
            acc_in = acc_ff + prod[37:0];
            mul_a  = TANH_D6;
            mul_b  = {7'd0, x6_ff};
         end
         ST_TH_D3: begin
            den_in = acc_ff + prod[37:0];
            mul_a  = TANH_N2;
            mul_b  = {16'd0, x2_ff};
         end
         ST_TH_N1: begin
            acc_in = TANH_C0 + prod[37:0];
            mul_a  = TANH_N4;
            mul_b  = {11'd0, x4_ff};
         end
         ST_TH_N2: begin
            mul_a = {4'd0, m_ff};
            mul_b = poly[35:0];
         end
         ST_TH_N3: begin
            div_req.start = 1'b1;
         end
         ST_TH_DIV: begin
         end
         // one-pole lowpass on the first tanh output
         ST_LP_ISSUE: begin
            sign_in = d[25];
            mul_a   = {8'd0, alpha_ff};
            mul_b   = {11'd0, d_mag};
         end
         ST_LP_UPD: begin
            lp_in   = lp_new[23:0];
            sign_in = lp_new[25];
            mul_a   = {9'd0, ogain_ff};
            mul_b   = {12'd0, lp_mag};
         end
         ST_G1: begin
            mul_a = K09_Q15;
            mul_b = {10'd0, prod[38:13]};
         end
         ST_G2: begin
            m_in    = prod[42:23];
            pass_in = 1'b1;
         end
         default: begin
         end
      endcase

      // hold each tanh result for the lowpass
      if (th_done) begin
         th_in = th_signed;
      end

      // second tanh delivers the sample
      if (th_done && pass_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = th_signed;
      end

      // register writes
      if (csr_wr) begin
         case (csr_idx)
            REG_ENABLED: begin
               if (enabled_ff && !csr_pwdata[0]) begin
                  voice_on_in = 1'b0;
               end
               if (!enabled_ff && csr_pwdata[0]) begin
                  lp_in = '0;
               end
               enabled_in = csr_pwdata[0];
            end
            REG_DECAY_COEFF: decay_in = csr_pwdata[23:0];
            REG_DRIVE_GAIN:  drive_in = csr_pwdata[15:0];
            REG_TONE_ALPHA:  alpha_in = csr_pwdata[15:0];
            REG_OUTPUT_GAIN: ogain_in = csr_pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (csr_idx)
         REG_ENABLED:     csr_prdata = {31'd0, enabled_ff};
         REG_DECAY_COEFF: csr_prdata = {8'd0, decay_ff};
         REG_DRIVE_GAIN:  csr_prdata = {16'd0, drive_ff};
         REG_TONE_ALPHA:  csr_prdata = {16'd0, alpha_ff};
         REG_OUTPUT_GAIN: csr_prdata = {17'd0, ogain_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= 1'b0;
         decay_ff     <= DECAY_RESET;
         drive_ff     <= DRIVE_RESET;
         alpha_ff     <= ALPHA_RESET;
         ogain_ff     <= OGAIN_RESET;
         voice_on_ff  <= 1'b0;
         phase_ff     <= '0;
         step_ff      <= STEP_TAB[0];
         env_ff       <= '0;
         vel_ff       <= '0;
         lp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         decay_ff     <= decay_in;
         drive_ff     <= drive_in;
         alpha_ff     <= alpha_in;
         ogain_ff     <= ogain_in;
         voice_on_ff  <= voice_on_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         env_ff       <= env_in;
         vel_ff       <= vel_in;
         lp_ff        <= lp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sign_ff     <= sign_in;
      m_ff        <= m_in;
      x2_ff       <= x2_in;
      x4_ff       <= x4_in;
      x6_ff       <= x6_in;
      acc_ff      <= acc_in;
      den_ff      <= den_in;
      pass_ff     <= pass_in;
      th_ff       <= th_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------- checks
   a_env_above_floor: assert property (@(posedge clock) disable iff (reset)
      voice_on_ff |-> env_ff >= ENV_FLOOR)
      else $error("voice on with envelope below floor");

   a_silent_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_tick && !voice_live) |=> rsp_valid_ff)
      else $error("silent tick did not produce a beat");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_TH_DIV)
      else $error("divider finished outside its wait state");

   a_busy_no_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a tick is in flight");

endmodule

`default_nettype wire

// File: hw/rtl/dsdv_mul.sv
//------------------------------------------------------------------------------
// dsdv_mul
// Shared unsigned multiplier with a registered product.
//------------------------------------------------------------------------------
`default_nettype none

module dsdv_mul import dsdv_pkg::*; (
   input  wire logic               clock,
   input  wire logic [MUL_A_W-1:0] op_a,
   input  wire logic [MUL_B_W-1:0] op_b,
   output logic      [MUL_P_W-1:0] prod
);

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   // full-width unsigned product
   assign prod_in = {{MUL_B_W{1'b0}}, op_a} * {{MUL_A_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dsdv_div.sv
//------------------------------------------------------------------------------
// dsdv_div
// Restoring divider for the tanh ratio: one quotient bit per cycle,
// quotient saturated at the Q15 maximum.
//------------------------------------------------------------------------------
`default_nettype none

module dsdv_div import dsdv_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] dsh_ff, dsh_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic                 sat;
   logic                 ge;

   // quotient of 2^15 or more clamps straight away
   assign sat = {1'b0, req.den, 15'd0} <= req.num;
   assign ge  = rem_ff >= dsh_ff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (req.start) begin
         if (sat) begin
            q_in    = Q15_MAX;
            done_in = 1'b1;
         end else begin
            rem_in = req.num;
            dsh_in = {2'd0, req.den, 14'd0};
            q_in   = '0;
            cnt_in = 4'd14;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         // trial subtract of the shifted divisor
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[DIV_Q_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == 4'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dsdv_sine_rom.sv
//------------------------------------------------------------------------------
// dsdv_sine_rom
// Q1.15 sine table over one turn, built at elaboration, registered read.
//------------------------------------------------------------------------------
`default_nettype none

module dsdv_sine_rom import dsdv_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] rd_addr,
   output logic signed [15:0]                       rd_data
);

   localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [15:0] rom_type [SINE_TABLE_DEPTH];

   // Taylor series in Q30, mirrored per quadrant, rounded to Q15
   function automatic logic signed [15:0] sine_q15(input logic [31:0] ph);
      logic [63:0]        f;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic signed [63:0] sum;
      logic [15:0]        res;
      f = {34'd0, ph[29:0]};
      if (ph[30]) begin
         f = 64'h40000000 - f;
      end
      x    = (f * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      // odd terms down to x^11 / 11!, alternating sign
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      mag = (64'(sum) + 64'd16384) >> 15;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      res = ph[31] ? 16'(-mag) : mag[15:0];
      return res;
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         t[i] = sine_q15(32'(64'(i) << (32 - ADDR_W)));
      end
      return t;
   endfunction

   localparam rom_type ROM = build_rom();

   logic signed [15:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= ROM[rd_addr];
   end

   assign rd_data = data_ff;

endmodule

`default_nettype wire

// File: sim/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for decaying_sine_drum_voice_core: drives MIDI events
// and sample ticks over the request stream, reprograms the voice registers
// between phases, and compares every returned sample with a bit-exact
// fixed-point model of the voice kept in a small scoreboard class.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import dsdv_pkg::*;

   // Bit-exact model of the voice plus the queue of samples still owed
   class drum_voice_scoreboard;
      shortint            sine_tab[1024];
      bit                 en;
      bit [23:0]          decay;
      bit [15:0]          drive;
      bit [15:0]          alpha;
      bit [14:0]          ogain;
      bit                 voice_on;
      bit [31:0]          phase;
      bit [31:0]          step;
      bit [23:0]          env;
      bit [15:0]          vel_scale;
      int                 lp;
      logic [15:0]        owed_samples[$];
      int                 mismatches;
      int                 samples_checked;
      int                 notes_started;
      int                 voice_ends;

      function new();
         for (int i = 0; i < 1024; i++)
            sine_tab[i] = shortint'(sine_at(32'(i) << 22));
         en = 0;
         decay = DECAY_RESET;
         drive = DRIVE_RESET;
         alpha = ALPHA_RESET;
         ogain = OGAIN_RESET;
         voice_on = 0;
         phase = 0;
         step = note_step(7'd0);
         env = 0;
         vel_scale = 0;
         lp = 0;
      endfunction

      // quarter-wave Taylor series in Q30, rounded to Q15
      function int sine_at(bit [31:0] ph);
         longint unsigned f, x, x2, term, mag;
         longint          sum;
         f = ph[29:0];
         if (ph[30])
            f = 64'h4000_0000 - f;
         x = (f * 64'd1686629713) >> 30;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
               sum = sum - longint'(term);
            else
               sum = sum + longint'(term);
         end
         if (sum < 0)
            sum = 0;
         mag = (longint'(sum) + 16384) >> 15;
         if (mag > 32767)
            mag = 32767;
         return ph[31] ? -int'(mag) : int'(mag);
      endfunction

      // phase increment of a note, semitone power built in Q2.30
      function bit [31:0] note_step(bit [6:0] n);
         int unsigned     d, oct, semi;
         longint unsigned r, num, den;
         d = n + 51;
         oct = d / 12;
         semi = d % 12;
         r = 64'd1 << 30;
         for (int i = 0; i < semi; i++)
            r = (r * 64'd1137589835 + (64'd1 << 29)) >> 30;
         num = (64'd1760 * r) << oct;
         den = 64'd44100 << 10;
         return 32'((num + den / 2) / den);
      endfunction

      // sign-magnitude multiply, truncating toward zero
      function longint scale(longint a, longint unsigned b, int sh);
         longint unsigned m, r;
         m = (a < 0) ? longint'(-a) : longint'(a);
         r = (m * b) >> sh;
         return (a < 0) ? -longint'(r) : longint'(r);
      endfunction

      // [7/6] continued-fraction tanh, Q15 in and out
      function longint soft_clip(longint x);
         longint unsigned m, r, x2, x4, x6, num, den;
         m = (x < 0) ? longint'(-x) : longint'(x);
         if (m >= TANH_LIMIT) begin
            r = 32767;
         end else begin
            x2 = (m * m) >> 15;
            x4 = (x2 * x2) >> 15;
            x6 = (x4 * x2) >> 15;
            num = m * (64'd135135 * 64'd32768 + 64'd17325 * x2 + 64'd378 * x4 + x6);
            den = 64'd135135 * 64'd32768 + 64'd62370 * x2 + 64'd3150 * x4 + 64'd28 * x6;
            r = num / den;
            if (r > 32767)
               r = 32767;
         end
         return (x < 0) ? -longint'(r) : longint'(r);
      endfunction

      function void write_reg(bit [2:0] idx, bit [31:0] val);
         case (idx)
            REG_ENABLED: begin
               if (en && !val[0])
                  voice_on = 0;
               if (!en && val[0])
                  lp = 0;
               en = val[0];
            end
            REG_DECAY_COEFF: decay = val[23:0];
            REG_DRIVE_GAIN:  drive = val[15:0];
            REG_TONE_ALPHA:  alpha = val[15:0];
            REG_OUTPUT_GAIN: ogain = val[14:0];
            default: ;
         endcase
      endfunction

      // accepted request beat: update voice state, queue the sample a tick owes
      function void note_req(bit op, bit [1:0] len, bit [7:0] status, bit [6:0] note,
                             bit [6:0] vel);
         int unsigned     vs;
         longint          s;
         longint unsigned e;
         if (op == OP_MIDI) begin
            if (en && len >= EVENT_FULL_LEN && status[7:4] == STATUS_NOTE_ON && vel != 0) begin
               vs = (int'(vel) * 32768 + 63) / 127;
               voice_on = 1;
               phase = 0;
               env = ENV_FULL;
               vel_scale = (vs < VEL_MIN) ? VEL_MIN : 16'(vs);
               step = note_step(note);
               notes_started++;
            end
            return;
         end
         if (!en || !voice_on) begin
            owed_samples.push_back(16'd0);
            return;
         end
         s = sine_tab[phase[31:22]];
         phase = phase + step;
         e = (longint'(env) * longint'(decay)) >> 24;
         env = 24'(e);
         if (env < ENV_FLOOR) begin
            env = 0;
            voice_on = 0;
            voice_ends++;
            owed_samples.push_back(16'd0);
            return;
         end
         s = scale(s, env, 24);
         s = scale(s, vel_scale, 15);
         s = scale(s, K065_Q15, 15);
         s = soft_clip(scale(s, drive, 12));
         lp = lp + int'(scale(s * 256 - longint'(lp), alpha, 16));
         s = scale(longint'(lp), ogain, 13);
         s = scale(s, K09_Q15, 15);
         s = scale(s, 1, 8);
         s = soft_clip(s);
         owed_samples.push_back(s[15:0]);
      endfunction

      function void check_sample(logic [15:0] got);
         logic [15:0] want;
         samples_checked++;
         if (owed_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: sample %h with none expected", $realtime, got);
            return;
         end
         want = owed_samples.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: audio_sample expected %h got %h", $realtime, want, got);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;  // event_length[1:0], midi_status[9:2],
                                 // note_number[16:10], note_velocity[23:17]
   logic        req_tuser = 0;   // operation[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;       // audio_sample[15:0]
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int send_idle_pct = 0;
   int sink_stall_pct = 0;
   drum_voice_scoreboard voice_sb = new();

   decaying_sine_drum_voice_core dut (.*);

   always #5 clock = ~clock;

   // result side: random stalls, check every beat taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         voice_sb.check_sample(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   task automatic send_beat(bit op, bit [1:0] len, bit [7:0] status, bit [6:0] note,
                            bit [6:0] vel);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {vel, note, status, len};
      do @(posedge clock); while (!req_tready);
      voice_sb.note_req(op, len, status, note, vel);
   endtask

   task automatic tick();
      send_beat(OP_TICK, 2'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
   endtask

   task automatic note_on(bit [7:0] status, bit [6:0] note, bit [6:0] vel);
      send_beat(OP_MIDI, EVENT_FULL_LEN, status, note, vel);
   endtask

   // wait until every owed sample is back, then let the core settle
   task automatic drain();
      req_tvalid <= 0;
      while (voice_sb.owed_samples.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(bit [2:0] idx, bit [31:0] val);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      voice_sb.write_reg(idx, val);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic set_voice(bit [23:0] dcy, bit [15:0] drv, bit [15:0] alp, bit [14:0] og);
      csr_write(REG_DECAY_COEFF, {8'hA5, dcy});
      csr_write(REG_DRIVE_GAIN, {16'h5A5A, drv});
      csr_write(REG_TONE_ALPHA, {16'hFFFF, alp});
      csr_write(REG_OUTPUT_GAIN, {17'h1FFFF, og});
   endtask

   // mostly ticks with regular note-ons; a few fully random beats
   task automatic random_beats(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 88)
            tick();
         else if (r < 96)
            note_on({4'h9, 4'($urandom)}, 7'($urandom), 7'($urandom_range(127, 1)));
         else
            send_beat(1'($urandom), 2'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;

      // disabled block: silence, note-on ignored
      send_idle_pct = 19;
      sink_stall_pct = 64;
      tick();
      note_on(8'h90, 7'd60, 7'd100);
      drain();

      // zero decay: envelope dies on the first tick
      csr_write(REG_ENABLED, 32'hFFFF_FFFF);
      csr_write(REG_DECAY_COEFF, 32'd0);
      note_on(8'h9F, 7'd127, 7'd127);
      tick();
      tick();
      drain();

      // high drive and gains, fastest lowpass
      set_voice(24'd15000000, 16'd34816, 16'd65535, 15'd32619);
      csr_write(3'd7, 32'hDEAD_BEEF);
      note_on(8'h90, 7'd0, 7'd1);
      repeat (3) tick();
      note_on(8'h95, 7'd127, 7'd127);
      repeat (4) tick();
      note_on(8'h90, 7'd64, 7'd0);
      send_beat(OP_MIDI, 2'd2, 8'h90, 7'd30, 7'd90);
      note_on(8'h80, 7'd30, 7'd90);
      note_on(8'hFF, 7'd30, 7'd90);
      send_beat(OP_MIDI, 2'd0, 8'h00, 7'd0, 7'd0);
      repeat (2) tick();
      send_beat(OP_TICK, 2'd3, 8'hFF, 7'd127, 7'd127);
      random_beats(630);
      drain();

      // disable clears the voice, enable clears the filter; slow settings
      send_idle_pct = 64;
      sink_stall_pct = 19;
      csr_write(REG_ENABLED, 32'd0);
      csr_write(REG_ENABLED, 32'd1);
      set_voice(24'd16777215, 16'd4096, 16'd3000, 15'd2058);
      random_beats(650);
      drain();

      // mid settings, no idling on either side
      send_idle_pct = 0;
      sink_stall_pct = 0;
      set_voice(24'd14000000, 16'd20000, 16'd40000, 15'd12000);
      random_beats(650);
      drain();

      $display("Checked %0d samples over %0d note-ons, %0d envelope ends, three register sets",
               voice_sb.samples_checked, voice_sb.notes_started, voice_sb.voice_ends);
      $display("Mismatches: %0d, samples still owed: %0d",
               voice_sb.mismatches, voice_sb.owed_samples.size());
      if (voice_sb.mismatches == 0 && voice_sb.owed_samples.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule
